/* rtl/nfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared constants and types of the nibble framebuffer blitter.
// ----------------------------------------------------------------------------
package nfb_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 192;
    localparam int BYTES_PER_ROW = 80;
    localparam int SPRITE_SIZE   = 8;

    localparam int BUF_BYTES = BYTES_PER_ROW * SCREEN_HEIGHT;
    localparam int MEM_DEPTH = 2 * BUF_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int OFF_W     = $clog2(BUF_BYTES + SCREEN_WIDTH);

    localparam int SPR_BITS  = $clog2(SPRITE_SIZE);
    localparam int MASK_W    = SPRITE_SIZE * SPRITE_SIZE;

    // signed working width for unclipped coordinates (position plus extent)
    localparam int COORD_W   = 12;
    localparam int X_W       = $clog2(SCREEN_WIDTH + 1);
    localparam int Y_W       = ($clog2(SCREEN_HEIGHT + 1) > SPR_BITS) ?
                               $clog2(SCREEN_HEIGHT + 1) : SPR_BITS;

    localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SCREEN_WIDTH);
    localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SCREEN_HEIGHT);
    localparam logic signed [COORD_W-1:0] SPR_S = COORD_W'(SPRITE_SIZE);
    localparam logic [SPR_BITS-1:0] SPR_MAX = SPR_BITS'(SPRITE_SIZE - 1);

    localparam logic [7:0] HI_MASK = 8'hf0;
    localparam logic [7:0] LO_MASK = 8'h0f;

    localparam int OP_W       = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_FILL    = 3'd1,
        OP_SPRITE  = 3'd2,
        OP_PRESENT = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_RUN,
        ST_DRAIN,
        ST_RD_WAIT,
        ST_DONE
    } st_t;

endpackage
`default_nettype wire

/* rtl/nfb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/nibble_framebuffer_blitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_framebuffer_blitter
// Two 4bpp framebuffers in one frame memory; clear, fill, sprite, swap, read.
// ----------------------------------------------------------------------------
// steps: clear, fill and sprite go setup, start, run, drain, with one read-modify-write
//   per byte in run; an empty or clipped-away area goes from start to done; present and
//   unused opcodes go setup to done, read via read wait; done waits on a held result
// throughput: one command at a time, ready again as its result word is presented
// reset: buffer one is the back buffer, buffer zero is shown; frame memory is
//   not initialized and needs a clear before it is read
// ----------------------------------------------------------------------------
module nibble_framebuffer_blitter import nfb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pos_x, pos_y, rect_width, rect_height, pen_color, sprite_mask, mirror,
    // read_address, read_front
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [OP_W-1:0]       s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // read_data, front_index
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    st_t st_reg, st_next;

    // command word
    op_t                op_reg;
    logic signed [9:0]  px_reg, py_reg;
    logic signed [8:0]  w_reg, h_reg;
    logic [3:0]         color_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic               flip_reg;
    logic [13:0]        raddr_reg;
    logic               rfront_reg;

    logic back_reg, back_next;

    // clipped bounds
    logic [X_W-1:0] x0_reg, x0_next, x1_reg, x1_next, bx_last_reg, bx_last_next;
    logic [Y_W-1:0] y0_reg, y0_next, y_last_reg, y_last_next;
    logic           live_reg, live_next;

    // walker
    logic [X_W-1:0]   cur_bx_reg, cur_bx_next;
    logic [Y_W-1:0]   cur_y_reg, cur_y_next;
    logic [OFF_W-1:0] row_off_reg, row_off_next;

    // write stage and forwarding of the last write
    logic              wp_valid_reg, wp_valid_next;
    logic [ADDR_W-1:0] wp_addr_reg, wp_addr_next;
    logic              wp_hi_reg, wp_hi_next, wp_lo_reg, wp_lo_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg, fwd_addr_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;

    logic       rdok_reg, rdok_next;
    logic [7:0] rdata_reg, rdata_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] out_rdata_reg, out_rdata_next;
    logic       out_front_reg, out_front_next;

    // memory port
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic in_fire, out_free;

    // setup arithmetic
    logic signed [COORD_W-1:0] xs, xe, ys, ye, cx0, cx1, cy0, cy1;

    // walk arithmetic
    logic [OFF_W-1:0]    off;
    logic                in_buf, is_sprite, last_col, last_row;
    logic [X_W:0]        pix_e, pix_o;
    logic                in_e, in_o;
    logic [SPR_BITS-1:0] col_e, col_o, spr_row;
    logic [7:0]          merge_src;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - 9)'(0), out_front_reg, out_rdata_reg};

    nfb_ram #(
        .DATA_W (8),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg     <= op_t'(s_tuser);
            px_reg     <= s_tdata[9:0];
            py_reg     <= s_tdata[19:10];
            w_reg      <= s_tdata[28:20];
            h_reg      <= s_tdata[37:29];
            color_reg  <= s_tdata[41:38];
            mask_reg   <= s_tdata[105:42];
            flip_reg   <= s_tdata[106];
            raddr_reg  <= s_tdata[120:107];
            rfront_reg <= s_tdata[121];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            back_reg      <= 1'b1;
            wp_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            st_reg        <= st_next;
            back_reg      <= back_next;
            wp_valid_reg  <= wp_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        bx_last_reg   <= bx_last_next;
        y0_reg        <= y0_next;
        y_last_reg    <= y_last_next;
        live_reg      <= live_next;
        cur_bx_reg    <= cur_bx_next;
        cur_y_reg     <= cur_y_next;
        row_off_reg   <= row_off_next;
        wp_addr_reg   <= wp_addr_next;
        wp_hi_reg     <= wp_hi_next;
        wp_lo_reg     <= wp_lo_next;
        fwd_addr_reg  <= fwd_addr_next;
        fwd_data_reg  <= fwd_data_next;
        rdok_reg      <= rdok_next;
        rdata_reg     <= rdata_next;
        out_rdata_reg <= out_rdata_next;
        out_front_reg <= out_front_next;
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    st_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                case (op_reg)
                    OP_CLEAR, OP_FILL, OP_SPRITE: st_next = ST_START;
                    OP_READ:                      st_next = ST_RD_WAIT;
                    default:                      st_next = ST_DONE;
                endcase
            end
            ST_START: begin
                st_next = live_reg ? ST_RUN : ST_DONE;
            end
            ST_RUN: begin
                if (last_col && last_row) begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   st_next = ST_DONE;
            ST_RD_WAIT: st_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // unclipped extent of the command
    always_comb begin
        case (op_reg)
            OP_CLEAR: begin
                xs = '0;
                xe = SW_S;
                ys = '0;
                ye = SH_S;
            end
            OP_SPRITE: begin
                xs = COORD_W'(px_reg);
                xe = COORD_W'(px_reg) + SPR_S;
                ys = COORD_W'(py_reg);
                ye = COORD_W'(py_reg) + SPR_S;
            end
            default: begin
                xs = COORD_W'(px_reg);
                xe = COORD_W'(px_reg) + COORD_W'(w_reg);
                ys = COORD_W'(py_reg);
                ye = COORD_W'(py_reg) + COORD_W'(h_reg);
            end
        endcase
        cx0 = (xs < 0) ? '0 : xs;
        cx1 = (xe > SW_S) ? SW_S : xe;
        cy0 = (ys < 0) ? '0 : ys;
        cy1 = (ye > SH_S) ? SH_S : ye;
    end

    // walk helpers
    always_comb begin
        off       = row_off_reg + OFF_W'(cur_bx_reg);
        in_buf    = off < OFF_W'(BUF_BYTES);
        is_sprite = (op_reg == OP_SPRITE);
        last_col  = (cur_bx_reg == bx_last_reg);
        last_row  = (cur_y_reg == y_last_reg);
        pix_e     = {cur_bx_reg, 1'b0};
        pix_o     = {cur_bx_reg, 1'b1};
        in_e      = (pix_e >= {1'b0, x0_reg}) && (pix_e < {1'b0, x1_reg});
        in_o      = (pix_o >= {1'b0, x0_reg}) && (pix_o < {1'b0, x1_reg});
        // sprite column and row taken modulo the sprite size
        col_e     = pix_e[SPR_BITS-1:0] - px_reg[SPR_BITS-1:0];
        col_o     = pix_o[SPR_BITS-1:0] - px_reg[SPR_BITS-1:0];
        if (flip_reg) begin
            col_e = SPR_MAX - col_e;
            col_o = SPR_MAX - col_o;
        end
        spr_row   = cur_y_reg[SPR_BITS-1:0] - py_reg[SPR_BITS-1:0];
        merge_src = (fwd_valid_reg && (fwd_addr_reg == wp_addr_reg)) ?
                    fwd_data_reg : ram_rdata;
    end

    // datapath and memory control
    always_comb begin
        back_next      = back_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        bx_last_next   = bx_last_reg;
        y0_next        = y0_reg;
        y_last_next    = y_last_reg;
        live_next      = live_reg;
        cur_bx_next    = cur_bx_reg;
        cur_y_next     = cur_y_reg;
        row_off_next   = row_off_reg;
        wp_valid_next  = 1'b0;
        wp_addr_next   = wp_addr_reg;
        wp_hi_next     = wp_hi_reg;
        wp_lo_next     = wp_lo_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;
        rdok_next      = rdok_reg;
        rdata_next     = rdata_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_rdata_next = out_rdata_reg;
        out_front_next = out_front_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        ram_we         = 1'b0;
        ram_waddr      = wp_addr_reg;
        ram_wdata      = merge_src;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // merge the nibbles of the byte read last cycle and write it back
        if (wp_valid_reg) begin
            ram_wdata[7:4] = wp_hi_reg ? color_reg : merge_src[7:4];
            ram_wdata[3:0] = wp_lo_reg ? color_reg : merge_src[3:0];
            ram_we         = wp_hi_reg || wp_lo_reg;
            if (ram_we) begin
                fwd_valid_next = 1'b1;
                fwd_addr_next  = wp_addr_reg;
                fwd_data_next  = ram_wdata;
            end
        end

        case (st_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    rdata_next = '0;
                end
            end
            ST_SETUP: begin
                live_next    = (cx0 < cx1) && (cy0 < cy1);
                x0_next      = X_W'(cx0);
                x1_next      = X_W'(cx1);
                bx_last_next = X_W'((cx1 - 1) >>> 1);
                y0_next      = Y_W'(cy0);
                y_last_next  = Y_W'(cy1 - 1);
                if (op_reg == OP_PRESENT) begin
                    back_next = ~back_reg;
                end
                if (op_reg == OP_READ) begin
                    ram_re    = 1'b1;
                    ram_raddr = ((rfront_reg ^ back_reg) ? ADDR_W'(BUF_BYTES) : '0)
                                + ADDR_W'(raddr_reg);
                    rdok_next = 32'(raddr_reg) < 32'(BUF_BYTES);
                end
            end
            ST_START: begin
                cur_bx_next  = x0_reg >> 1;
                cur_y_next   = y0_reg;
                row_off_next = OFF_W'(OFF_W'(y0_reg) * OFF_W'(BYTES_PER_ROW));
            end
            ST_RUN: begin
                ram_re        = 1'b1;
                ram_raddr     = (back_reg ? ADDR_W'(BUF_BYTES) : '0) + ADDR_W'(off);
                wp_valid_next = 1'b1;
                wp_addr_next  = ram_raddr;
                wp_hi_next    = in_buf && in_e && (!is_sprite || mask_reg[{spr_row, col_e}]);
                wp_lo_next    = in_buf && in_o && (!is_sprite || mask_reg[{spr_row, col_o}]);
                if (last_col) begin
                    cur_bx_next  = x0_reg >> 1;
                    cur_y_next   = cur_y_reg + 1'b1;
                    row_off_next = row_off_reg + OFF_W'(BYTES_PER_ROW);
                end else begin
                    cur_bx_next = cur_bx_reg + 1'b1;
                end
            end
            ST_RD_WAIT: begin
                rdata_next = rdok_reg ? ram_rdata : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_rdata_next = rdata_reg;
                    out_front_next = ~back_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives draw, swap, read and unused commands into the blitter with random gaps on
// the command side and random stalls on the result side. A class keeps its
// own copy of both framebuffers and the back select. It predicts each result
// word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module testbench;
    import nfb_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int GAP_MAX        = 17;
    localparam int RANDOM_ITEMS   = 265;
    localparam int BLOCK_ITEMS    = 30;
    localparam int WATCHDOG_LIMIT = 65536;
    localparam int END_WAIT       = 64;

    typedef struct {
        logic [OP_W-1:0]    opcode;
        logic signed [9:0]  pos_x;
        logic signed [9:0]  pos_y;
        logic signed [8:0]  rect_width;
        logic signed [8:0]  rect_height;
        logic [3:0]         pen_color;
        logic [MASK_W-1:0]  sprite_mask;
        logic               mirror;
        logic [13:0]        read_address;
        logic               read_front;
    } blit_cmd_t;

    typedef struct {
        logic [7:0] read_data;
        logic       front_index;
    } reply_t;

    // shadow copy of both framebuffers plus the words still owed by the block
    class frame_mirror;
        logic [7:0] pixels [MEM_DEPTH];
        bit         back_sel;
        reply_t     owed_words [$];
        int         errors;

        function new();
            back_sel = 1'b1;
            errors   = 0;
        endfunction

        function int outstanding();
            return owed_words.size();
        endfunction

        function void plot(int bank, int x, int y, logic [3:0] c);
            int idx;
            int at;
            if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
            idx = y * BYTES_PER_ROW + x / 2;
            if (idx >= BUF_BYTES) return;
            at = bank * BUF_BYTES + idx;
            // even column lives in the high nibble
            if (x % 2 == 1)
                pixels[at] = (pixels[at] & HI_MASK) | {4'h0, c};
            else
                pixels[at] = (pixels[at] & LO_MASK) | {c, 4'h0};
        endfunction

        function void fill_area(int bank, int x, int y, int w, int h, logic [3:0] c);
            int x0, x1, y0, y1;
            if (w <= 0 || h <= 0) return;
            x0 = (x < 0) ? 0 : x;
            x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
            y0 = (y < 0) ? 0 : y;
            y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
            for (int r = y0; r < y1; r++)
                for (int k = x0; k < x1; k++)
                    plot(bank, k, r, c);
        endfunction

        function void apply_command(blit_cmd_t c);
            int     bank;
            int     col;
            reply_t r;
            bank = int'(back_sel);
            r.read_data = 8'h00;
            case (c.opcode)
                OP_CLEAR: begin
                    fill_area(bank, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, c.pen_color);
                end
                OP_FILL: begin
                    fill_area(bank, int'(c.pos_x), int'(c.pos_y), int'(c.rect_width),
                              int'(c.rect_height), c.pen_color);
                end
                OP_SPRITE: begin
                    for (int r0 = 0; r0 < SPRITE_SIZE; r0++) begin
                        for (int k = 0; k < SPRITE_SIZE; k++) begin
                            col = c.mirror ? (SPRITE_SIZE - 1 - k) : k;
                            if (c.sprite_mask[r0 * SPRITE_SIZE + col])
                                plot(bank, int'(c.pos_x) + k, int'(c.pos_y) + r0,
                                     c.pen_color);
                        end
                    end
                end
                OP_PRESENT: begin
                    back_sel = ~back_sel;
                end
                OP_READ: begin
                    if (int'(c.read_address) < BUF_BYTES)
                        r.read_data = pixels[(c.read_front ? bank ^ 1 : bank) * BUF_BYTES
                                             + int'(c.read_address)];
                end
                default: begin
                end
            endcase
            r.front_index = ~back_sel;
            owed_words.push_back(r);
        endfunction

        function void match_word(logic [OUT_DATA_W-1:0] w);
            reply_t e;
            if (owed_words.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with nothing expected", $time, w);
                return;
            end
            e = owed_words.pop_front();
            if (w[7:0] !== e.read_data) begin
                errors++;
                $display("%0t: read_data expected %h actual %h", $time, e.read_data, w[7:0]);
            end
            if (w[8] !== e.front_index) begin
                errors++;
                $display("%0t: front_index expected %b actual %b", $time, e.front_index,
                         w[8]);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    frame_mirror model;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          last_x = 0;
    int          last_y = 0;

    nibble_framebuffer_blitter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [IN_DATA_W-1:0] pack_cmd(blit_cmd_t c);
        return IN_DATA_W'({c.read_front, c.read_address, c.mirror, c.sprite_mask,
                           c.pen_color, c.rect_height, c.rect_width, c.pos_y, c.pos_x});
    endfunction

    // called at a falling edge, returns at the falling edge after the accept
    task automatic send_cmd(blit_cmd_t c);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = pack_cmd(c);
        s_tuser  = c.opcode;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model.apply_command(c);
        if (c.opcode == OP_FILL || c.opcode == OP_SPRITE) begin
            last_x = (c.pos_x < 0) ? 0 : (c.pos_x >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1
                                                                   : int'(c.pos_x);
            last_y = (c.pos_y < 0) ? 0 : (c.pos_y >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1
                                                                    : int'(c.pos_y);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (model.outstanding() != 0) @(negedge aclk);
    endtask

    task automatic directed(logic [OP_W-1:0] op, int x, int y, int w, int h,
                            logic [3:0] color, logic [MASK_W-1:0] mask, logic flip,
                            int addr, logic front);
        blit_cmd_t c;
        c.opcode       = op;
        c.pos_x        = 10'(x);
        c.pos_y        = 10'(y);
        c.rect_width   = 9'(w);
        c.rect_height  = 9'(h);
        c.pen_color    = color;
        c.sprite_mask  = mask;
        c.mirror       = flip;
        c.read_address = 14'(addr);
        c.read_front   = front;
        send_cmd(c);
    endtask

    function automatic blit_cmd_t random_cmd();
        blit_cmd_t c;
        int        pick;
        int        kind;
        int        rx, ry;
        // every field gets noise, then the fields the opcode uses are shaped
        c.pos_x        = 10'($urandom);
        c.pos_y        = 10'($urandom);
        c.rect_width   = 9'($urandom);
        c.rect_height  = 9'($urandom);
        c.pen_color    = 4'($urandom);
        c.sprite_mask  = {$urandom, $urandom};
        c.mirror       = 1'($urandom);
        c.read_address = 14'($urandom);
        c.read_front   = 1'($urandom);
        pick = int'($urandom_range(0, 99));
        kind = int'($urandom_range(0, 9));
        if (pick < 3) begin
            c.opcode = OP_CLEAR;
        end else if (pick < 10) begin
            c.opcode = OP_PRESENT;
        end else if (pick < 15) begin
            case ($urandom_range(0, 2))
                0:       c.opcode = OP_SPARE_5;
                1:       c.opcode = OP_SPARE_6;
                default: c.opcode = OP_SPARE_7;
            endcase
        end else if (pick < 40) begin
            c.opcode = OP_FILL;
            if (kind < 7) begin
                c.pos_x       = 10'(int'($urandom_range(0, SCREEN_WIDTH + 15)) - 10);
                c.pos_y       = 10'(int'($urandom_range(0, SCREEN_HEIGHT + 15)) - 10);
                c.rect_width  = 9'(int'($urandom_range(0, 23)) - 3);
                c.rect_height = 9'(int'($urandom_range(0, 23)) - 3);
            end else if (kind == 9) begin
                // big rectangles are slow, keep them rare
                c.pos_x       = 10'(int'($urandom_range(0, SCREEN_WIDTH + 30)) - 40);
                c.pos_y       = 10'(int'($urandom_range(0, SCREEN_HEIGHT)) - 40);
                c.rect_width  = 9'($urandom_range(0, 255));
                c.rect_height = 9'($urandom_range(0, 255));
            end
        end else if (pick < 65) begin
            c.opcode = OP_SPRITE;
            if (kind < 8) begin
                c.pos_x = 10'(int'($urandom_range(0, SCREEN_WIDTH + 15)) - 10);
                c.pos_y = 10'(int'($urandom_range(0, SCREEN_HEIGHT + 15)) - 10);
            end
            if (kind == 0)
                c.sprite_mask = '1;
            else if (kind == 1)
                c.sprite_mask = {$urandom & $urandom, $urandom & $urandom};
        end else begin
            c.opcode = OP_READ;
            if (kind < 6) begin
                ry = (last_y + int'($urandom_range(0, SPRITE_SIZE - 1))) % SCREEN_HEIGHT;
                rx = (last_x + int'($urandom_range(0, SPRITE_SIZE - 1))) % SCREEN_WIDTH;
                c.read_address = 14'(ry * BYTES_PER_ROW + rx / 2);
            end else if (kind < 9) begin
                c.read_address = 14'($urandom_range(0, BUF_BYTES - 1));
            end
        end
        return c;
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            model.match_word(m_tdata);
            stall_left = no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("nibble_framebuffer_blitter verification failed");
            $finish;
        end
    end

    initial begin
        model = new();
        aresetn = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // both buffers get written before anything is read back
        directed(OP_CLEAR,   0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_PRESENT, 0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_CLEAR,   0, 0, 0, 0, 4'h5, '0, 1'b0, 0, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b1);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, BUF_BYTES - 1, 1'b0);
        // addresses past the buffer read as zero
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, BUF_BYTES, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'hf, '1, 1'b1, 16383, 1'b1);
        // clipping on the left, top, right and bottom edges
        directed(OP_FILL,   -3, -2, 7, 5, 4'ha, '0, 1'b0, 0, 1'b0);
        directed(OP_FILL,  155, 188, 255, 255, 4'h3, '0, 1'b0, 0, 1'b0);
        // empty and fully off-screen rectangles
        directed(OP_FILL,   10, 10, 0, 20, 4'hf, '0, 1'b0, 0, 1'b0);
        directed(OP_FILL,   10, 10, 20, -256, 4'hf, '0, 1'b0, 0, 1'b0);
        directed(OP_FILL, -512, -512, 255, 255, 4'hf, '0, 1'b0, 0, 1'b0);
        directed(OP_FILL,  511, 511, 255, 255, 4'hf, '0, 1'b0, 0, 1'b0);
        directed(OP_FILL,    1, 0, 1, 1, 4'h9, '0, 1'b0, 0, 1'b0);
        directed(OP_SPRITE, -4, -4, 0, 0, 4'hf, '1, 1'b0, 0, 1'b0);
        directed(OP_SPRITE, 156, 188, 0, 0, 4'h6, 64'h0123_4567_89ab_cdef, 1'b1, 0, 1'b0);
        directed(OP_SPRITE, 40, 40, 0, 0, 4'hc, 64'h0123_4567_89ab_cdef, 1'b0, 0, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, 188 * BYTES_PER_ROW + 78, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, 40 * BYTES_PER_ROW + 20, 1'b0);
        directed(OP_SPARE_5, 0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_SPARE_6, 0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_SPARE_7, 0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_PRESENT, 0, 0, 0, 0, 4'h0, '0, 1'b0, 0, 1'b0);
        directed(OP_READ,    0, 0, 0, 0, 4'h0, '0, 1'b0, 40 * BYTES_PER_ROW + 21, 1'b1);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BLOCK_ITEMS == 0) begin
                no_idle = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
            end
            send_cmd(random_cmd());
        end
        s_tvalid = 1'b0;
        no_idle  = 1'b0;

        while (model.outstanding() != 0) @(negedge aclk);
        repeat (END_WAIT) @(negedge aclk);
        if (model.errors == 0 && model.outstanding() == 0)
            $display("nibble_framebuffer_blitter verification clean");
        else
            $display("nibble_framebuffer_blitter verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/nfb_pkg.sv
rtl/nfb_ram.sv
rtl/nibble_framebuffer_blitter.sv
tb/sv/testbench.sv
